// ===== rtl/vma_pkg.sv =====
// voxel memory accumulator package: commands, status codes, controller states
// no dependencies
package vma_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_READ = 2'd1,
    CMD_AGE  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_NEW     = 3'd1,
    ST_REPLACE = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_ERASED  = 3'd4,
    ST_KEPT    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_INV_VOXEL = 3'd0,
    REG_DECAY     = 3'd1,
    REG_MIN_HITS  = 3'd2,
    REG_DEF_RED   = 3'd3,
    REG_DEF_GREEN = 3'd4,
    REG_DEF_BLUE  = 3'd5
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_HASH,
    S_PROBE_RD,
    S_PROBE,
    S_WRITE,
    S_SLOT_RD,
    S_SLOT,
    S_DIV,
    S_DONE
  } state_e;

  // slot table size, tied to the 12-bit slot fields
  localparam int unsigned TableEntries = 4096;

  localparam int unsigned KeyW = 21;
  localparam int unsigned HashX = 32'd73856093;
  localparam int unsigned HashY = 32'd19349663;
  localparam int unsigned HashZ = 32'd83492791;

  // controller to datapath
  typedef struct packed {
    logic clear;       // zero one valid bit of the table
    logic capture;     // latch the command beat
    logic quantize;    // register the three products
    logic hash;        // form key and hash base
    logic probe_rd;    // issue read of probe slot
    logic probe_eval;  // evaluate returned probe entry
    logic commit;      // write the chosen slot
    logic slot_rd;     // issue read of addressed slot
    logic slot_eval;   // evaluate read or age
    logic div_start;   // start the mean divisions
    logic div_step;    // one division step
    logic done;        // drive the result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       clear_last;
    logic       probe_last;
    logic       need_div;
    logic       div_last;
  } stat_t;

endpackage

// ===== rtl/vma_ctrl.sv =====
// voxel memory accumulator controller: sequences add, read and age commands
// depends on vma_pkg
module vma_ctrl
  import vma_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  start_i,
  output logic  busy_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    busy_o  = (state_q != S_IDLE);
    unique case (state_q)
      // one table slot per cycle after reset
      S_CLEAR: begin
        ctrl_o.clear = 1'b1;
        if (stat_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.capture = 1'b1;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        unique case (stat_i.cmd)
          CMD_ADD: begin
            ctrl_o.quantize = 1'b1;
            state_d = S_HASH;
          end
          CMD_READ, CMD_AGE: begin
            ctrl_o.slot_rd = 1'b1;
            state_d = S_SLOT_RD;
          end
          default: state_d = S_DONE;
        endcase
      end
      S_HASH: begin
        ctrl_o.hash = 1'b1;
        state_d = S_PROBE_RD;
      end
      S_PROBE_RD: begin
        ctrl_o.probe_rd = 1'b1;
        state_d = S_PROBE;
      end
      S_PROBE: begin
        ctrl_o.probe_eval = 1'b1;
        state_d = stat_i.probe_last ? S_WRITE : S_PROBE_RD;
      end
      S_WRITE: begin
        ctrl_o.commit = 1'b1;
        state_d = S_DONE;
      end
      S_SLOT_RD: begin
        state_d = S_SLOT;
      end
      S_SLOT: begin
        ctrl_o.slot_eval = 1'b1;
        if (stat_i.need_div) begin
          ctrl_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DIV: begin
        ctrl_o.div_step = 1'b1;
        if (stat_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        ctrl_o.done = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/vma_datapath.sv =====
// voxel memory accumulator datapath: quantizer, hash, slot table memories,
// probe bookkeeping and a shared restoring divider for the means
// depends on vma_pkg
module vma_datapath
  import vma_pkg::*;
#(
  parameter int unsigned ProbeLimit   = 8,
  parameter int unsigned CountBits    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctrl_t              ctrl_i,
  output stat_t              stat_o,
  // config
  input  logic        [31:0] inv_voxel_size_i,
  input  logic        [31:0] decay_ticks_i,
  input  logic        [15:0] hit_floor_i,
  input  logic        [7:0]  def_red_i,
  input  logic        [7:0]  def_green_i,
  input  logic        [7:0]  def_blue_i,
  // command
  input  logic        [1:0]  cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic        [7:0]  red_in_i,
  input  logic        [7:0]  green_in_i,
  input  logic        [7:0]  blue_in_i,
  input  logic               color_present_i,
  input  logic        [31:0] stamp_i,
  input  logic        [11:0] slot_i,
  // result
  output logic               done_o,
  output logic        [2:0]  status_o,
  output logic        [11:0] slot_index_o,
  output logic        [15:0] hits_o,
  output logic signed [31:0] mean_x_o,
  output logic signed [31:0] mean_y_o,
  output logic signed [31:0] mean_z_o,
  output logic        [7:0]  mean_red_o,
  output logic        [7:0]  mean_green_o,
  output logic        [7:0]  mean_blue_o,
  output logic               reportable_o
);

  localparam int unsigned AddrW  = $clog2(TableEntries);
  localparam int unsigned ProbeW = (ProbeLimit > 1) ? $clog2(ProbeLimit) : 1;
  localparam int unsigned PosW   = 32 + CountBits;
  localparam int unsigned ColW   = 8 + CountBits;
  localparam int unsigned KeyAll = 3 * KeyW;
  localparam logic [CountBits-1:0] CountMax = '1;
  localparam int unsigned DivW   = PosW;
  localparam int unsigned DivCntW = $clog2(DivW + 1);

  // memories: one word per slot
  typedef struct packed {
    logic [KeyAll-1:0]    key;
    logic [CountBits-1:0] hits;
    logic [PosW-1:0]      sx;
    logic [PosW-1:0]      sy;
    logic [PosW-1:0]      sz;
    logic [ColW-1:0]      cr;
    logic [ColW-1:0]      cg;
    logic [ColW-1:0]      cb;
    logic                 col_seen;
    logic [31:0]          last_seen;
  } entry_t;

  entry_t mem_q [TableEntries];
  logic   valid_mem [TableEntries];
  entry_t rd_q;
  logic   rd_valid_q;

  // command registers
  logic [1:0]        cmd_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic [7:0]        cr_q, cg_q, cb_q;
  logic              pres_q;
  logic [31:0]       stamp_q;
  logic [11:0]       slot_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      px_q    <= pos_x_i;
      py_q    <= pos_y_i;
      pz_q    <= pos_z_i;
      pres_q  <= color_present_i;
      cr_q    <= color_present_i ? red_in_i : def_red_i;
      cg_q    <= color_present_i ? green_in_i : def_green_i;
      cb_q    <= color_present_i ? blue_in_i : def_blue_i;
      stamp_q <= stamp_i;
      slot_q  <= slot_i;
    end
  end

  // quantize: signed 32 x unsigned 32, keep bits 52:32
  logic signed [64:0] prod_x, prod_y, prod_z;
  logic [KeyW-1:0] kx_q, ky_q, kz_q;
  assign prod_x = px_q * $signed({1'b0, inv_voxel_size_i});
  assign prod_y = py_q * $signed({1'b0, inv_voxel_size_i});
  assign prod_z = pz_q * $signed({1'b0, inv_voxel_size_i});

  always_ff @(posedge clk_i) begin
    if (ctrl_i.quantize) begin
      kx_q <= prod_x[32 +: KeyW];
      ky_q <= prod_y[32 +: KeyW];
      kz_q <= prod_z[32 +: KeyW];
    end
  end

  // hash
  logic [31:0] hash_w;
  assign hash_w = (32'({11'd0, kx_q}) * HashX) ^ (32'({11'd0, ky_q}) * HashY)
                ^ (32'({11'd0, kz_q}) * HashZ);

  logic [KeyAll-1:0] key_q;
  logic [AddrW-1:0]  base_q;
  logic [ProbeW:0]   pcnt_q;
  logic [AddrW-1:0]  paddr_q;
  logic              found_q, have_empty_q, have_old_q;
  logic [AddrW-1:0]  hit_s_q, empty_s_q, old_s_q;
  logic [31:0]       best_age_q;
  entry_t            hit_e_q;

  logic [AddrW-1:0] probe_addr;
  assign probe_addr = base_q + AddrW'(pcnt_q);

  logic [31:0] p_age;
  assign p_age = stamp_q - rd_q.last_seen;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.hash) begin
      key_q        <= {kx_q, ky_q, kz_q};
      base_q       <= hash_w[AddrW-1:0];
      pcnt_q       <= '0;
      found_q      <= 1'b0;
      have_empty_q <= 1'b0;
      have_old_q   <= 1'b0;
    end
    if (ctrl_i.probe_rd) begin
      paddr_q <= probe_addr;
      pcnt_q  <= pcnt_q + 1'b1;
    end
    if (ctrl_i.probe_eval) begin
      if (rd_valid_q) begin
        if (!found_q && rd_q.key == key_q) begin
          found_q <= 1'b1;
          hit_s_q <= paddr_q;
          hit_e_q <= rd_q;
        end
        if (!have_old_q || p_age > best_age_q) begin
          have_old_q <= 1'b1;
          best_age_q <= p_age;
          old_s_q    <= paddr_q;
        end
      end else if (!have_empty_q) begin
        have_empty_q <= 1'b1;
        empty_s_q    <= paddr_q;
      end
    end
  end

  // new entry contents
  entry_t new_e, upd_e, wr_e;
  logic [AddrW-1:0] wr_s;
  always_comb begin
    new_e = '0;
    new_e.key       = key_q;
    new_e.hits      = CountBits'(1);
    new_e.sx        = PosW'(px_q);
    new_e.sy        = PosW'(py_q);
    new_e.sz        = PosW'(pz_q);
    new_e.cr        = ColW'(cr_q);
    new_e.cg        = ColW'(cg_q);
    new_e.cb        = ColW'(cb_q);
    new_e.col_seen  = pres_q;
    new_e.last_seen = stamp_q;
    upd_e = hit_e_q;
    if (hit_e_q.hits != CountMax) begin
      upd_e.sx        = hit_e_q.sx + PosW'(px_q);
      upd_e.sy        = hit_e_q.sy + PosW'(py_q);
      upd_e.sz        = hit_e_q.sz + PosW'(pz_q);
      upd_e.cr        = hit_e_q.cr + ColW'(cr_q);
      upd_e.cg        = hit_e_q.cg + ColW'(cg_q);
      upd_e.cb        = hit_e_q.cb + ColW'(cb_q);
      upd_e.hits      = hit_e_q.hits + 1'b1;
      upd_e.col_seen  = hit_e_q.col_seen | pres_q;
    end
    upd_e.last_seen = stamp_q;
    wr_e = found_q ? upd_e : new_e;
    wr_s = found_q ? hit_s_q : (have_empty_q ? empty_s_q : old_s_q);
  end

  // slot path
  logic slot_in_range;
  assign slot_in_range = (32'(slot_q) < TableEntries);
  logic [AddrW-1:0] slot_a;
  assign slot_a = slot_q[AddrW-1:0];
  logic [31:0] s_age;
  assign s_age = stamp_q - rd_q.last_seen;
  logic erase;
  assign erase = ctrl_i.slot_eval && (cmd_q == CMD_AGE) && slot_in_range && rd_valid_q
              && (decay_ticks_i != '0) && (s_age > decay_ticks_i);

  // clearing pass over the valid bits after reset
  logic [AddrW-1:0] clr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (ctrl_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // single write port of the valid bits: clear, commit or erase
  logic             v_we, v_bit;
  logic [AddrW-1:0] v_addr;
  always_comb begin
    v_we   = ctrl_i.clear | ctrl_i.commit | erase;
    v_bit  = ctrl_i.commit;
    v_addr = ctrl_i.clear ? clr_q : (ctrl_i.commit ? wr_s : slot_a);
  end

  // memory read and write
  logic [AddrW-1:0] rd_addr;
  assign rd_addr = ctrl_i.probe_rd ? probe_addr : slot_a;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.probe_rd || ctrl_i.slot_rd) rd_q <= mem_q[rd_addr];
    if (ctrl_i.commit) mem_q[wr_s] <= wr_e;
    if (v_we) valid_mem[v_addr] <= v_bit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (ctrl_i.probe_rd || ctrl_i.slot_rd) begin
      rd_valid_q <= valid_mem[rd_addr];
    end
  end

  // shared restoring divider: six dividends by the hit count, one bit a step
  logic [DivW-1:0]      dq_q [6];
  logic [CountBits:0]   dr_q [6];
  logic [CountBits-1:0] dv_q;
  logic [5:0]           dneg_q;
  logic [DivCntW-1:0]   dcnt_q;
  logic                 dcol_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_start) begin
      dv_q   <= rd_q.hits;
      dcnt_q <= '0;
      dcol_q <= rd_q.col_seen;
      dneg_q <= {3'b000, rd_q.sz[PosW-1], rd_q.sy[PosW-1], rd_q.sx[PosW-1]};
      dq_q[0] <= rd_q.sx[PosW-1] ? (DivW'(0) - rd_q.sx) : rd_q.sx;
      dq_q[1] <= rd_q.sy[PosW-1] ? (DivW'(0) - rd_q.sy) : rd_q.sy;
      dq_q[2] <= rd_q.sz[PosW-1] ? (DivW'(0) - rd_q.sz) : rd_q.sz;
      dq_q[3] <= DivW'(rd_q.cr);
      dq_q[4] <= DivW'(rd_q.cg);
      dq_q[5] <= DivW'(rd_q.cb);
      for (int k = 0; k < 6; k++) dr_q[k] <= '0;
    end else if (ctrl_i.div_step) begin
      dcnt_q <= dcnt_q + 1'b1;
      for (int k = 0; k < 6; k++) begin
        logic [CountBits+1:0] trial;
        trial = {dr_q[k], dq_q[k][DivW-1]} - {2'b00, dv_q};
        if (!trial[CountBits+1]) begin
          dr_q[k] <= trial[CountBits:0];
          dq_q[k] <= {dq_q[k][DivW-2:0], 1'b1};
        end else begin
          dr_q[k] <= {dr_q[k][CountBits-1:0], dq_q[k][DivW-1]};
          dq_q[k] <= {dq_q[k][DivW-2:0], 1'b0};
        end
      end
    end
  end

  function automatic logic [31:0] fix_sign(input logic [DivW-1:0] q, input logic neg);
    logic [DivW-1:0] r;
    r = neg ? (DivW'(0) - q) : q;
    return r[31:0];
  endfunction

  function automatic logic [7:0] sat8(input logic [DivW-1:0] q);
    return (q > DivW'(255)) ? 8'hFF : q[7:0];
  endfunction

  // result registers
  logic [2:0]  st_q;
  logic [11:0] si_q;
  logic [CountBits-1:0] h_q;
  logic        rep_q, rdm_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      st_q  <= ST_EMPTY;
      si_q  <= '0;
      h_q   <= '0;
      rep_q <= 1'b0;
      rdm_q <= 1'b0;
    end
    if (ctrl_i.commit) begin
      st_q  <= found_q ? ST_HIT : (have_empty_q ? ST_NEW : ST_REPLACE);
      si_q  <= 12'(wr_s);
      h_q   <= wr_e.hits;
      rep_q <= (32'(wr_e.hits) >= 32'(hit_floor_i));
    end
    if (ctrl_i.slot_eval) begin
      si_q <= slot_q;
      if (slot_in_range && rd_valid_q) begin
        h_q <= rd_q.hits;
        if (cmd_q == CMD_READ) begin
          st_q  <= ST_HIT;
          rep_q <= (32'(rd_q.hits) >= 32'(hit_floor_i));
          rdm_q <= 1'b1;
        end else begin
          st_q <= erase ? ST_ERASED : ST_KEPT;
        end
      end
    end
  end

  logic hits_zero;
  assign hits_zero = (dv_q == '0);

  always_comb begin
    done_o       = ctrl_i.done;
    status_o     = st_q;
    slot_index_o = si_q;
    hits_o       = (32'(h_q) > 32'hFFFF) ? 16'hFFFF : 16'(h_q);
    reportable_o = rep_q;
    mean_x_o = '0; mean_y_o = '0; mean_z_o = '0;
    mean_red_o = '0; mean_green_o = '0; mean_blue_o = '0;
    if (rdm_q) begin
      mean_x_o = hits_zero ? '0 : fix_sign(dq_q[0], dneg_q[0]);
      mean_y_o = hits_zero ? '0 : fix_sign(dq_q[1], dneg_q[1]);
      mean_z_o = hits_zero ? '0 : fix_sign(dq_q[2], dneg_q[2]);
      if (dcol_q && !hits_zero) begin
        mean_red_o   = sat8(dq_q[3]);
        mean_green_o = sat8(dq_q[4]);
        mean_blue_o  = sat8(dq_q[5]);
      end else begin
        mean_red_o   = def_red_i;
        mean_green_o = def_green_i;
        mean_blue_o  = def_blue_i;
      end
    end
  end

  assign stat_o.cmd        = cmd_q;
  assign stat_o.clear_last = (clr_q == AddrW'(TableEntries - 1));
  assign stat_o.probe_last = (pcnt_q == (ProbeW+1)'(ProbeLimit));
  assign stat_o.need_div   = (cmd_q == CMD_READ) && slot_in_range && rd_valid_q;
  assign stat_o.div_last   = (dcnt_q == DivCntW'(DivW - 1));

endmodule

// ===== rtl/voxel_memory_accumulator.sv =====
// voxel memory accumulator top level: config registers, controller, datapath
// depends on vma_pkg, vma_ctrl, vma_datapath
//
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+------------------------------------
// command  | in        | start / busy       | cmd_i, pos_*_i, colors, stamp_i, slot_i
// result   | out       | done_o strobe      | status_o .. reportable_o
// config   | in        | cfg_we_i           | cfg_idx_i, cfg_data_i
//
// command sequencing, from the accepting edge to the result beat
// add: the probe loop reads and evaluates PROBE_LIMIT slots, one slot at a time
// read of a valid slot: also runs the bit-serial divider to form the means
// age and empty read: one slot read, no division; unused command: no table access
// after reset busy stays high for a pass over all 4096 slots that zeroes the valid bits
// result beat lasts one cycle on done_o; the receiver cannot stall
module voxel_memory_accumulator
  import vma_pkg::*;
#(
  parameter int unsigned PROBE_LIMIT   = 8,
  parameter int unsigned COUNT_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic        [2:0]  cfg_idx_i,
  input  logic        [31:0] cfg_data_i,
  input  logic        [1:0]  cmd_i,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic        [7:0]  red_in_i,
  input  logic        [7:0]  green_in_i,
  input  logic        [7:0]  blue_in_i,
  input  logic               color_present_i,
  input  logic        [31:0] stamp_i,
  input  logic        [11:0] slot_i,
  output logic               done_o,
  output logic        [2:0]  status_o,
  output logic        [11:0] slot_index_o,
  output logic        [15:0] hits_o,
  output logic signed [31:0] mean_x_o,
  output logic signed [31:0] mean_y_o,
  output logic signed [31:0] mean_z_o,
  output logic        [7:0]  mean_red_o,
  output logic        [7:0]  mean_green_o,
  output logic        [7:0]  mean_blue_o,
  output logic               reportable_o
);

  // configuration registers
  logic [31:0] inv_voxel_q, decay_q;
  logic [15:0] hit_floor_q;
  logic [7:0]  def_red_q, def_green_q, def_blue_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_voxel_q <= 32'd2184533;
      decay_q     <= 32'd0;
      hit_floor_q <= 16'd30;
      def_red_q   <= 8'd0;
      def_green_q <= 8'd100;
      def_blue_q  <= 8'd255;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INV_VOXEL: inv_voxel_q <= cfg_data_i;
        REG_DECAY:     decay_q     <= cfg_data_i;
        REG_MIN_HITS:  hit_floor_q <= cfg_data_i[15:0];
        REG_DEF_RED:   def_red_q   <= cfg_data_i[7:0];
        REG_DEF_GREEN: def_green_q <= cfg_data_i[7:0];
        REG_DEF_BLUE:  def_blue_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ctrl_t ctrl;
  stat_t stat;

  // sequencer
  vma_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  // table, quantizer, divider
  vma_datapath #(
    .ProbeLimit   (PROBE_LIMIT),
    .CountBits    (COUNT_BITS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .inv_voxel_size_i (inv_voxel_q),
    .decay_ticks_i    (decay_q),
    .hit_floor_i      (hit_floor_q),
    .def_red_i        (def_red_q),
    .def_green_i      (def_green_q),
    .def_blue_i       (def_blue_q),
    .cmd_i            (cmd_i),
    .pos_x_i          (pos_x_i),
    .pos_y_i          (pos_y_i),
    .pos_z_i          (pos_z_i),
    .red_in_i         (red_in_i),
    .green_in_i       (green_in_i),
    .blue_in_i        (blue_in_i),
    .color_present_i  (color_present_i),
    .stamp_i          (stamp_i),
    .slot_i           (slot_i),
    .done_o           (done_o),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .hits_o           (hits_o),
    .mean_x_o         (mean_x_o),
    .mean_y_o         (mean_y_o),
    .mean_z_o         (mean_z_o),
    .mean_red_o       (mean_red_o),
    .mean_green_o     (mean_green_o),
    .mean_blue_o      (mean_blue_o),
    .reportable_o     (reportable_o)
  );

`ifndef SYNTHESIS
  // a result beat only comes while a command is in flight
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy) else $error("result beat while idle");
  // the block goes idle right after the result beat
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy) else $error("busy after result beat");
  // an accepted command makes the block busy next cycle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("command not taken");
`endif

endmodule
